### src/alr_pkg.sv
`default_nettype none

package alr_pkg;

  // Width of the colour alpha and of a quantized coverage value.
  localparam int unsigned ALPHA_BITS = 8;

  // Command selector carried on the input tuser.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

endpackage

`default_nettype wire

### src/antialiased_line_rasterizer_unit.sv
`default_nettype none

// Wu-style antialiased line rasterizer. A start item (tuser = 0) loads two
// endpoints and produces no output; a step item (tuser = 1) produces one column
// of two pixels with alpha-scaled coverage, tlast marking the final column. A
// step with no line active is consumed silently. The block handles one item at
// a time: a start runs the bit-serial gradient divider unless both endpoints
// coincide; a step runs the single 8x8 alpha multiplier, which serves both
// pixels in turn, and may wait for the output register to drain. The output
// register lets a new item be accepted while the previous column still waits
// to be taken.
module antialiased_line_rasterizer_unit #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [alr_pkg::ALPHA_BITS-1:0] cfg_data_i,   // color_alpha
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  wire logic                          s_axis_tuser_i, // command
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // first_x, first_y, first_alpha, first_shown,
  // second_x, second_y, second_alpha, second_shown
  output logic [((4*(COORD_BITS+1)+2*alr_pkg::ALPHA_BITS+2+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                               m_axis_tlast_o  // last
);

  localparam int unsigned AW     = alr_pkg::ALPHA_BITS;
  localparam int unsigned OW     = COORD_BITS + 1;
  localparam int unsigned IW     = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned SW     = FRAC_BITS + 2;
  localparam int unsigned OutW   = 4 * OW + 2 * AW + 2;
  localparam int unsigned OutTdW = ((OutW + 7) / 8) * 8;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ORIENT = 3'd1;
  localparam logic [2:0] ST_ORDER  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_COV1   = 3'd4;
  localparam logic [2:0] ST_COV2   = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  localparam logic signed [SW-1:0] SlopeOne = {2'b01, {FRAC_BITS{1'b0}}};

  logic [2:0]            state_q, state_d;
  logic [AW-1:0]         alpha_q, alpha_d;
  logic                  active_q, active_d;
  logic                  steep_q, steep_d;
  logic                  neg_q, neg_d;
  logic [COORD_BITS-1:0] p0x_q, p0x_d, p0y_q, p0y_d, p1x_q, p1x_d, p1y_q, p1y_d;
  logic [COORD_BITS-1:0] major_pos_q, major_pos_d, major_end_q, major_end_d;
  logic signed [IW-1:0]  icpt_q, icpt_d;
  logic signed [SW-1:0]  slope_q, slope_d;
  logic [AW-1:0]         alpha1_q, alpha1_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutTdW-1:0]     out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;

  logic                  in_fire;
  logic                  emit_fire;

  // Orientation and ordering.
  logic [COORD_BITS-1:0] adx, ady, xs, xe, ys, ye, dx, dy_abs;
  logic                  steep, swap_pts;

  // Column math.
  logic [FRAC_BITS-1:0]  frac;
  logic [FRAC_BITS:0]    one_minus;
  logic [FRAC_BITS+8:0]  prod1, prod2;
  logic [AW-1:0]         cov1, cov2, cov_sel;
  logic [OW-1:0]         m1, m2, mj;
  logic                  is_last;
  logic signed [IW-1:0]  icpt_sum;
  logic [OutW-1:0]       packed_out;

  logic                  div_start;
  logic                  div_done;
  logic [FRAC_BITS:0]    div_quot;
  logic                  shade_en;
  logic [AW-1:0]         shade_val;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);

  assign adx   = (p1x_q >= p0x_q) ? (p1x_q - p0x_q) : (p0x_q - p1x_q);
  assign ady   = (p1y_q >= p0y_q) ? (p1y_q - p0y_q) : (p0y_q - p1y_q);
  assign steep = ady > adx;

  assign swap_pts = p0x_q > p1x_q;
  assign xs       = swap_pts ? p1x_q : p0x_q;
  assign xe       = swap_pts ? p0x_q : p1x_q;
  assign ys       = swap_pts ? p1y_q : p0y_q;
  assign ye       = swap_pts ? p0y_q : p1y_q;
  assign dx       = xe - xs;
  assign dy_abs   = (ye >= ys) ? (ye - ys) : (ys - ye);

  assign frac      = icpt_q[FRAC_BITS-1:0];
  assign one_minus = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
  assign prod1     = {one_minus, 8'd0} - {8'd0, one_minus};
  assign prod2     = {1'b0, frac, 8'd0} - {9'd0, frac};
  assign cov1      = prod1[FRAC_BITS+7:FRAC_BITS];
  assign cov2      = prod2[FRAC_BITS+7:FRAC_BITS];
  assign cov_sel   = (state_q == ST_COV2) ? cov2 : cov1;

  assign m1      = icpt_q[IW-1:FRAC_BITS];
  assign m2      = m1 + 1'b1;
  assign mj      = {1'b0, major_pos_q};
  assign is_last = major_pos_q >= major_end_q;
  assign icpt_sum = icpt_q + {{(IW-SW){slope_q[SW-1]}}, slope_q};

  assign packed_out = {
    (cov2 != '0), shade_val, (steep_q ? mj : m2), (steep_q ? m2 : mj),
    (cov1 != '0), alpha1_q,  (steep_q ? mj : m1), (steep_q ? m1 : mj)
  };

  assign div_start = (state_q == ST_ORDER) && (dx != '0);
  assign shade_en  = (state_q == ST_COV1) || (state_q == ST_COV2);

  alr_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dy_abs),
    .den_i   (dx),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  alr_shade u_shade (
    .clk_i    (clk_i),
    .en_i     (shade_en),
    .alpha_i  (alpha_q),
    .cov_i    (cov_sel),
    .scaled_o (shade_val)
  );

  always_comb begin
    state_d     = state_q;
    alpha_d     = alpha_q;
    active_d    = active_q;
    steep_d     = steep_q;
    neg_d       = neg_q;
    p0x_d       = p0x_q;
    p0y_d       = p0y_q;
    p1x_d       = p1x_q;
    p1y_d       = p1y_q;
    major_pos_d = major_pos_q;
    major_end_d = major_end_q;
    icpt_d      = icpt_q;
    slope_d     = slope_q;
    alpha1_d    = alpha1_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    if (cfg_valid_i) begin
      alpha_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser_i == alr_pkg::CMD_START) begin
            // Drop any running line and latch the new endpoints.
            active_d = 1'b0;
            p0x_d    = s_axis_tdata_i[COORD_BITS-1:0];
            p0y_d    = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
            p1x_d    = s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS];
            p1y_d    = s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS];
            state_d  = ST_ORIENT;
          end else if (active_q) begin
            state_d = ST_COV1;
          end
        end
      end
      ST_ORIENT: begin
        steep_d = steep;
        if (steep) begin
          p0x_d = p0y_q;
          p0y_d = p0x_q;
          p1x_d = p1y_q;
          p1y_d = p1x_q;
        end
        state_d = ST_ORDER;
      end
      ST_ORDER: begin
        major_pos_d = xs;
        major_end_d = xe;
        icpt_d      = {1'b0, ys, {FRAC_BITS{1'b0}}};
        neg_d       = ye < ys;
        if (dx == '0) begin
          slope_d  = SlopeOne;
          active_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          slope_d  = neg_q ? (SW'(0) - {1'b0, div_quot}) : {1'b0, div_quot};
          active_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_COV1: begin
        state_d = ST_COV2;
      end
      ST_COV2: begin
        alpha1_d = shade_val;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          out_data_d  = OutTdW'(packed_out);
          out_last_d  = is_last;
          if (is_last) begin
            active_d = 1'b0;
          end else begin
            major_pos_d = major_pos_q + 1'b1;
            // Clamp the intercept at zero.
            icpt_d = icpt_sum[IW-1] ? '0 : icpt_sum;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      alpha_q     <= '1;
      active_q    <= 1'b0;
      steep_q     <= 1'b0;
      major_pos_q <= '0;
      major_end_q <= '0;
      icpt_q      <= '0;
      slope_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alpha_q     <= alpha_d;
      active_q    <= active_d;
      steep_q     <= steep_d;
      major_pos_q <= major_pos_d;
      major_end_q <= major_end_d;
      icpt_q      <= icpt_d;
      slope_q     <= slope_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    p0x_q      <= p0x_d;
    p0y_q      <= p0y_d;
    p1x_q      <= p1x_d;
    p1y_q      <= p1y_d;
    alpha1_q   <= alpha1_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the gradient state");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser_i == alr_pkg::CMD_STEP) && !active_q) |=>
      (state_q == ST_IDLE) && !out_valid_q || (state_q == ST_IDLE))
    else $error("step without a line started work");

  a_icpt_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !icpt_q[IW-1])
    else $error("intercept went negative");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && is_last) |=> !active_q && out_last_q && out_valid_q)
    else $error("last column did not end the line");

  a_slope_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ((slope_q <= SlopeOne) && (slope_q >= -SlopeOne)))
    else $error("gradient magnitude above one");

endmodule

`default_nettype wire

### src/alr_div.sv
`default_nettype none

// Restoring divider for the line gradient: quot = (num << FRAC_BITS) / den.
// The caller guarantees num <= den and den != 0, so the quotient is at most 1.0.
module alr_div #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [COORD_BITS-1:0] num_i,
  input  wire logic [COORD_BITS-1:0] den_i,
  output logic                       done_o,
  output logic [FRAC_BITS:0]         quot_o
);

  localparam int unsigned CntW = $clog2(FRAC_BITS + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(FRAC_BITS - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] den_q, den_d;
  logic [FRAC_BITS:0]    quot_q, quot_d;

  logic [COORD_BITS:0]   rem_shift;
  logic [COORD_BITS:0]   rem_diff;
  logic                  rem_ge;
  logic                  init_ge;

  assign rem_shift = {rem_q, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, den_q};
  assign rem_ge    = rem_shift >= {1'b0, den_q};
  assign init_ge   = num_i >= den_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = den_i;
      rem_d  = init_ge ? (num_i - den_i) : num_i;
      quot_d = {{FRAC_BITS{1'b0}}, init_ge};
    end else if (busy_q) begin
      // One quotient bit per cycle.
      rem_d  = rem_ge ? rem_diff[COORD_BITS-1:0] : rem_shift[COORD_BITS-1:0];
      quot_d = {quot_q[FRAC_BITS-1:0], rem_ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

### src/alr_shade.sv
`default_nettype none

// Coverage scaling: floor(alpha * cov / 255). The 8x8 product is registered,
// then divided by 255 with the add-and-shift identity, exact for 16-bit products.
module alr_shade (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [alr_pkg::ALPHA_BITS-1:0] alpha_i,
  input  wire logic [alr_pkg::ALPHA_BITS-1:0] cov_i,
  output logic      [alr_pkg::ALPHA_BITS-1:0] scaled_o
);

  localparam int unsigned ProdW = 2 * alr_pkg::ALPHA_BITS;

  logic [ProdW-1:0] prod_q, prod_d;
  logic [ProdW:0]   approx;

  assign prod_d = ProdW'(alpha_i) * ProdW'(cov_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign approx   = {1'b0, prod_q} + (ProdW + 1)'(prod_q >> alr_pkg::ALPHA_BITS) + 1'b1;
  assign scaled_o = approx[ProdW-1:alr_pkg::ALPHA_BITS];

endmodule

`default_nettype wire
